// ===== hdl/wrsg_pkg.sv =====
// wrsg_pkg: shared types and constants of the wrapped row segment generator
// holds register indexes, field widths, state and segment codes, table structs
// no dependencies
package wrsg_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_WIDTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_X_START  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_X_END    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 3'd5;

  // field widths
  localparam int unsigned PLANE_W = 24;
  localparam int unsigned ROW_W   = 18;
  localparam int unsigned OFF_W   = 48;
  localparam int unsigned LEN_W   = 22;

  // sequencer that rebuilds the segment table after reset or a register write
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DIV,
    ST_SETTLE,
    ST_RUN
  } cfg_state_e;

  // segment slots in emission order
  typedef enum logic [1:0] {
    SEG_TAIL,
    SEG_LPAD,
    SEG_MAIN,
    SEG_RPAD
  } seg_e;

  // image geometry used by the row base pipeline
  typedef struct packed {
    logic [15:0] row_length;
    logic [15:0] row_count;
    logic [3:0]  bytes_per_pixel;
  } geom_t;

  // per-row segment plan, identical for every in-image row
  typedef struct packed {
    logic [3:0]       en;
    logic [LEN_W-1:0] len_tail;
    logic [LEN_W-1:0] len_lpad;
    logic [LEN_W-1:0] len_main;
    logic [LEN_W-1:0] len_rpad;
    logic [LEN_W-1:0] len_oor;
    logic [OFF_W-1:0] coloff_tail;
    logic [OFF_W-1:0] coloff_main;
  } seg_tab_t;

endpackage

// ===== hdl/wrsg_cfg.sv =====
// wrsg_cfg: configuration registers and the segment plan derived from them
// runs a serial remainder unit for the wrap shift, then a three-stage plan build
// depends on wrsg_pkg
module wrsg_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wrsg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [wrsg_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output logic                               plan_ready_o,
  output wrsg_pkg::geom_t                    geom_o,
  output wrsg_pkg::seg_tab_t                 tab_o
);

  localparam logic [4:0] DIV_LAST    = 5'd17;
  localparam logic [4:0] SETTLE_LAST = 5'd2;

  // pixel count to byte length, negative counts give zero
  function automatic logic [wrsg_pkg::LEN_W-1:0] seg_len(input logic signed [20:0] n,
                                                         input logic [3:0] b);
    logic [23:0] p;
    p = 24'(n[19:0]) * 24'(b);
    if (n[20]) begin
      seg_len = '0;
    end else begin
      seg_len = p[wrsg_pkg::LEN_W-1:0];
    end
  endfunction

  // column to signed byte offset, sign extended to the offset width
  function automatic logic [wrsg_pkg::OFF_W-1:0] col_bytes(input logic signed [20:0] col,
                                                           input logic [3:0] b);
    logic signed [24:0] p;
    p = 25'(col) * 25'($signed({1'b0, b}));
    col_bytes = wrsg_pkg::OFF_W'(p);
  endfunction

  // configuration registers
  logic [15:0]        row_length_q, row_count_q, wrap_width_q;
  logic signed [17:0] x_start_q, x_end_q;
  logic [3:0]         bpp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= 16'd1;
      row_count_q  <= 16'd1;
      wrap_width_q <= 16'd0;
      x_start_q    <= '0;
      x_end_q      <= '0;
      bpp_q        <= 4'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wrsg_pkg::REG_ROW_LENGTH:      row_length_q <= cfg_wdata_i[15:0];
        wrsg_pkg::REG_ROW_COUNT:       row_count_q  <= cfg_wdata_i[15:0];
        wrsg_pkg::REG_WRAP_WIDTH:      wrap_width_q <= cfg_wdata_i[15:0];
        wrsg_pkg::REG_WINDOW_X_START:  x_start_q    <= $signed(cfg_wdata_i);
        wrsg_pkg::REG_WINDOW_X_END:    x_end_q      <= $signed(cfg_wdata_i);
        wrsg_pkg::REG_BYTES_PER_PIXEL: bpp_q        <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  wrsg_pkg::cfg_state_e state_q, state_d;
  logic [4:0]           cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wrsg_pkg::ST_LOAD;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      wrsg_pkg::ST_LOAD: begin
        state_d = wrsg_pkg::ST_DIV;
        cnt_d   = '0;
      end
      wrsg_pkg::ST_DIV: begin
        if (cnt_q == DIV_LAST) begin
          state_d = wrsg_pkg::ST_SETTLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      wrsg_pkg::ST_SETTLE: begin
        if (cnt_q == SETTLE_LAST) begin
          state_d = wrsg_pkg::ST_RUN;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      wrsg_pkg::ST_RUN: ;
      default: state_d = wrsg_pkg::ST_LOAD;
    endcase
    // any register write restarts the plan build
    if (cfg_we_i) begin
      state_d = wrsg_pkg::ST_LOAD;
    end
  end

  assign plan_ready_o = (state_q == wrsg_pkg::ST_RUN);

  // serial remainder of |window_x_end| by wrap_width, one quotient bit a cycle
  logic [17:0] dvd_q;
  logic [15:0] rem_q;
  logic [16:0] trial;

  assign trial = {rem_q, dvd_q[17]};

  always_ff @(posedge clk_i) begin
    if (state_q == wrsg_pkg::ST_LOAD) begin
      dvd_q <= x_end_q[17] ? 18'(-x_end_q) : x_end_q;
      rem_q <= '0;
    end else if (state_q == wrsg_pkg::ST_DIV) begin
      dvd_q <= {dvd_q[16:0], 1'b0};
      if (trial >= {1'b0, wrap_width_q}) begin
        rem_q <= 16'(trial - {1'b0, wrap_width_q});
      end else begin
        rem_q <= trial[15:0];
      end
    end
  end

  // plan stage 0: shifted window edges
  logic               wnz_q;
  logic signed [20:0] x0_q, xe_q, lw_q, w_q, len_q, n_oor_q;
  logic signed [20:0] rem_s, x_start_s, x_end_s;

  assign rem_s     = x_end_q[17] ? -$signed({5'b0, rem_q}) : $signed({5'b0, rem_q});
  assign x_start_s = 21'(x_start_q);
  assign x_end_s   = 21'(x_end_q);

  always_ff @(posedge clk_i) begin
    wnz_q   <= (wrap_width_q != 16'd0);
    w_q     <= $signed({5'b0, wrap_width_q});
    len_q   <= $signed({5'b0, row_length_q});
    lw_q    <= $signed({5'b0, row_length_q}) - $signed({5'b0, wrap_width_q});
    n_oor_q <= x_end_s - x_start_s;
    if (wrap_width_q != 16'd0) begin
      x0_q <= x_start_s - x_end_s + rem_s;
      xe_q <= rem_s;
    end else begin
      x0_q <= x_start_s;
      xe_q <= x_end_s;
    end
  end

  // plan stage 1: which segments exist, their pixel counts and columns
  logic               tail_en, lpad_en, main_en, rpad_en;
  logic signed [20:0] xa, xb, xc, xm;
  logic signed [20:0] n_tail, n_lpad, n_main, n_rpad, col_tail;

  always_comb begin
    tail_en  = x0_q[20] && wnz_q && (x0_q < lw_q);
    n_tail   = lw_q - x0_q;
    col_tail = w_q + x0_q;
    xa       = tail_en ? lw_q : x0_q;
    lpad_en  = xa[20];
    n_lpad   = -xa;
    xb       = lpad_en ? '0 : xa;
    main_en  = (xb < len_q);
    xm       = (xe_q < len_q) ? xe_q : len_q;
    n_main   = xm - xb;
    xc       = main_en ? xm : xb;
    rpad_en  = (xc < xe_q);
    n_rpad   = xe_q - xc;
  end

  logic [3:0]         en_q;
  logic signed [20:0] n_tail_q, n_lpad_q, n_main_q, n_rpad_q, n_oor1_q;
  logic signed [20:0] col_tail_q, col_main_q;

  always_ff @(posedge clk_i) begin
    en_q[wrsg_pkg::SEG_TAIL] <= tail_en;
    en_q[wrsg_pkg::SEG_LPAD] <= lpad_en;
    en_q[wrsg_pkg::SEG_MAIN] <= main_en;
    en_q[wrsg_pkg::SEG_RPAD] <= rpad_en;
    n_tail_q   <= n_tail;
    n_lpad_q   <= n_lpad;
    n_main_q   <= n_main;
    n_rpad_q   <= n_rpad;
    n_oor1_q   <= n_oor_q;
    col_tail_q <= col_tail;
    col_main_q <= xb;
  end

  // plan stage 2: byte lengths and column byte offsets
  wrsg_pkg::seg_tab_t tab_q;

  always_ff @(posedge clk_i) begin
    tab_q.en          <= en_q;
    tab_q.len_tail    <= seg_len(n_tail_q, bpp_q);
    tab_q.len_lpad    <= seg_len(n_lpad_q, bpp_q);
    tab_q.len_main    <= seg_len(n_main_q, bpp_q);
    tab_q.len_rpad    <= seg_len(n_rpad_q, bpp_q);
    tab_q.len_oor     <= seg_len(n_oor1_q, bpp_q);
    tab_q.coloff_tail <= col_bytes(col_tail_q, bpp_q);
    tab_q.coloff_main <= col_bytes(col_main_q, bpp_q);
  end

  assign tab_o                  = tab_q;
  assign geom_o.row_length      = row_length_q;
  assign geom_o.row_count       = row_count_q;
  assign geom_o.bytes_per_pixel = bpp_q;

endmodule

// ===== hdl/wrapped_row_segment_generator_top.sv =====
// wrapped_row_segment_generator_top: row request to copy and zero-fill segments
// six-stage row base pipeline and a segment emitter; plan from wrsg_cfg
// depends on wrsg_pkg, wrsg_cfg
//
//   channel  handshake                  payload
//   in       in_valid_i / in_ready_o    plane_index_i, row_number_i
//   out      out_valid_o / out_ready_i  fill_zero_o, byte_offset_o, byte_length_o,
//                                       last_segment_o
//   cfg      cfg_we_i (no wait)         cfg_idx_i, cfg_wdata_i
//
// A request takes one input transfer and one output transfer per segment (1 to 4, or
// none for an empty request); its first segment comes from the emitter after stages 1 to 6.
// The output port sets the rate: the emitter holds a row until all its segments go.
// After reset and after every register write, in_ready_o stays low while the serial
// remainder unit (18 steps) and the plan stages rebuild the plan. Stalls on the output
// back up through per-stage valid bits; nothing is dropped.
module wrapped_row_segment_generator_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [wrsg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [wrsg_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // row requests
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [wrsg_pkg::PLANE_W-1:0]       plane_index_i,
  input  logic signed [wrsg_pkg::ROW_W-1:0]  row_number_i,
  // segments
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               fill_zero_o,
  output logic [wrsg_pkg::OFF_W-1:0]         byte_offset_o,
  output logic [wrsg_pkg::LEN_W-1:0]         byte_length_o,
  output logic                               last_segment_o
);

  logic               plan_ready;
  wrsg_pkg::geom_t    geom;
  wrsg_pkg::seg_tab_t tab;

  wrsg_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .plan_ready_o (plan_ready),
    .geom_o       (geom),
    .tab_o        (tab)
  );

  // stage valid bits and advance enables
  logic [6:1] v_q;
  logic [6:1] adv;
  logic       e_free;

  assign adv[6] = !v_q[6] || e_free;
  assign adv[5] = !v_q[5] || adv[6];
  assign adv[4] = !v_q[4] || adv[5];
  assign adv[3] = !v_q[3] || adv[4];
  assign adv[2] = !v_q[2] || adv[3];
  assign adv[1] = !v_q[1] || adv[2];

  assign in_ready_o = plan_ready && adv[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[1]) v_q[1] <= in_valid_i && in_ready_o;
      if (adv[2]) v_q[2] <= v_q[1];
      if (adv[3]) v_q[3] <= v_q[2];
      if (adv[4]) v_q[4] <= v_q[3];
      if (adv[5]) v_q[5] <= v_q[4];
      if (adv[6]) v_q[6] <= v_q[5];
    end
  end

  // stage 1: capture request, classify the row
  logic [wrsg_pkg::PLANE_W-1:0] s1_plane_q;
  logic [15:0]                  s1_y_q;
  logic                         s1_oor_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s1_plane_q <= plane_index_i;
      s1_y_q     <= row_number_i[15:0];
      s1_oor_q   <= row_number_i[17] || (row_number_i[16:0] >= {1'b0, geom.row_count});
    end
  end

  // stage 2: rows before this plane
  logic [39:0] s2_rp_q;
  logic [15:0] s2_y_q;
  logic        s2_oor_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s2_rp_q  <= 40'(geom.row_count) * 40'(s1_plane_q);
      s2_y_q   <= s1_y_q;
      s2_oor_q <= s1_oor_q;
    end
  end

  // stage 3: absolute row index
  logic [39:0] s3_ri_q;
  logic        s3_oor_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s3_ri_q  <= s2_rp_q + 40'(s2_y_q);
      s3_oor_q <= s2_oor_q;
    end
  end

  // stage 4: pixel offset of the row
  logic [55:0]               s4_prod;
  logic [wrsg_pkg::OFF_W-1:0] s4_px_q;
  logic                      s4_oor_q;

  assign s4_prod = 56'(s3_ri_q) * 56'(geom.row_length);

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      s4_px_q  <= s4_prod[wrsg_pkg::OFF_W-1:0];
      s4_oor_q <= s3_oor_q;
    end
  end

  // stage 5: byte offset of the row
  logic [51:0]                s5_prod;
  logic [wrsg_pkg::OFF_W-1:0] s5_base_q;
  logic                       s5_oor_q;

  assign s5_prod = 52'(s4_px_q) * 52'(geom.bytes_per_pixel);

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      s5_base_q <= s5_prod[wrsg_pkg::OFF_W-1:0];
      s5_oor_q  <= s4_oor_q;
    end
  end

  // stage 6: copy source offsets and the segment mask
  logic [wrsg_pkg::OFF_W-1:0] s6_off_tail_q, s6_off_main_q;
  logic [3:0]                 s6_mask_q;
  logic                       s6_oor_q;

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      s6_off_tail_q <= s5_base_q + tab.coloff_tail;
      s6_off_main_q <= s5_base_q + tab.coloff_main;
      s6_mask_q     <= s5_oor_q ? 4'b0001 : tab.en;
      s6_oor_q      <= s5_oor_q;
    end
  end

  // emitter: hands out the pending segments of one row, lowest slot first
  logic [3:0]                 e_mask_q;
  logic                       e_oor_q;
  logic [wrsg_pkg::OFF_W-1:0] e_off_tail_q, e_off_main_q;
  logic                       e_take, e_single;

  assign e_single = ((e_mask_q & (e_mask_q - 4'd1)) == 4'd0);
  assign e_take   = out_valid_o && out_ready_i;
  assign e_free   = (e_mask_q == 4'd0) || (e_take && e_single);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_mask_q <= '0;
    end else if (e_free) begin
      e_mask_q <= v_q[6] ? s6_mask_q : 4'd0;
    end else if (e_take) begin
      e_mask_q <= e_mask_q & (e_mask_q - 4'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_free && v_q[6]) begin
      e_oor_q      <= s6_oor_q;
      e_off_tail_q <= s6_off_tail_q;
      e_off_main_q <= s6_off_main_q;
    end
  end

  // output selection from the lowest pending slot
  wrsg_pkg::seg_e sel;
  logic           seg_zero;
  logic [wrsg_pkg::LEN_W-1:0] seg_len;
  logic [wrsg_pkg::OFF_W-1:0] seg_off;

  always_comb begin
    priority if (e_mask_q[wrsg_pkg::SEG_TAIL]) sel = wrsg_pkg::SEG_TAIL;
    else if (e_mask_q[wrsg_pkg::SEG_LPAD])     sel = wrsg_pkg::SEG_LPAD;
    else if (e_mask_q[wrsg_pkg::SEG_MAIN])     sel = wrsg_pkg::SEG_MAIN;
    else                                       sel = wrsg_pkg::SEG_RPAD;

    unique case (sel)
      wrsg_pkg::SEG_TAIL: begin
        seg_zero = 1'b0;
        seg_len  = tab.len_tail;
        seg_off  = e_off_tail_q;
      end
      wrsg_pkg::SEG_LPAD: begin
        seg_zero = 1'b1;
        seg_len  = tab.len_lpad;
        seg_off  = '0;
      end
      wrsg_pkg::SEG_MAIN: begin
        seg_zero = 1'b0;
        seg_len  = tab.len_main;
        seg_off  = e_off_main_q;
      end
      default: begin
        seg_zero = 1'b1;
        seg_len  = tab.len_rpad;
        seg_off  = '0;
      end
    endcase

    // a row outside the image is a single zero fill of window width
    if (e_oor_q) begin
      seg_zero = 1'b1;
      seg_len  = tab.len_oor;
      seg_off  = '0;
    end
  end

  assign out_valid_o    = (e_mask_q != 4'd0);
  assign fill_zero_o    = seg_zero;
  assign byte_offset_o  = seg_off;
  assign byte_length_o  = seg_len;
  assign last_segment_o = e_single;

endmodule

// ===== tb/sv/tb_wrapped_row_segment_generator_top.sv =====
// tb_wrapped_row_segment_generator_top: self-checking bench for the row segment generator
// directed table then random rows over changing geometry, checked against a local predictor
// depends on wrsg_pkg and wrapped_row_segment_generator_top
module tb_wrapped_row_segment_generator_top;

  localparam int unsigned LIMIT       = 400000;
  localparam int unsigned SETTLE      = 24;
  localparam int unsigned MAX_REPORTS = 40;
  localparam int unsigned RAND_PHASES = 10;
  localparam int unsigned PHASE_ROWS  = 50;
  localparam int unsigned NUM_ROWS    = 22;

  typedef logic [wrsg_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [wrsg_pkg::CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [wrsg_pkg::PLANE_W-1:0]    plane_t;
  typedef logic signed [wrsg_pkg::ROW_W-1:0] row_t;

  // indexes past the last register; they change no register but still restart the plan build
  localparam cfg_idx_t REG_SPARE = 3'd6;

  // one segment transaction
  typedef struct packed {
    logic                       fill_zero;
    logic [wrsg_pkg::OFF_W-1:0] byte_offset;
    logic [wrsg_pkg::LEN_W-1:0] byte_length;
    logic                       last_segment;
  } segment_t;

  // raw write data of all six registers
  typedef struct packed {
    cfg_data_t row_length;
    cfg_data_t row_count;
    cfg_data_t wrap_width;
    cfg_data_t x_start;
    cfg_data_t x_end;
    cfg_data_t bytes_per_pixel;
  } setting_t;

  // one directed row request, with a literal answer where it is obvious
  typedef struct packed {
    logic [3:0] setting;
    plane_t     plane;
    row_t       row;
    logic       has_literal;
    segment_t   literal;
  } row_case_t;

  localparam segment_t NO_LITERAL = '0;

  // dut signals
  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  cfg_idx_t                   cfg_idx_i;
  cfg_data_t                  cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  plane_t                     plane_index_i;
  row_t                       row_number_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic                       fill_zero_o;
  logic [wrsg_pkg::OFF_W-1:0] byte_offset_o;
  logic [wrsg_pkg::LEN_W-1:0] byte_length_o;
  logic                       last_segment_o;

  // shadow of the register file, reset values
  logic [15:0]             cur_row_length = 16'd1;
  logic [15:0]             cur_row_count  = 16'd1;
  logic [15:0]             cur_wrap_width = 16'd0;
  logic signed [17:0]      cur_x_start    = 18'sd0;
  logic signed [17:0]      cur_x_end      = 18'sd0;
  logic [3:0]              cur_bpp        = 4'd1;

  segment_t                pending_segments[$];
  logic                    row_is_literal;
  segment_t                literal_seg;
  bit                      calm;
  int unsigned             error_count;
  int unsigned             rows_sent;
  int unsigned             segs_checked;
  int unsigned             settings_loaded;
  int unsigned             cycle_count;

  // geometry settings of the directed part; entry 0 is the reset state
  setting_t settings [0:8] = '{
    '{18'd1, 18'd1, 18'd0, 18'd0, 18'd0, 18'd1},
    '{18'd100, 18'd50, 18'd0, -18'sd10, 18'd120, 18'd2},
    '{18'd360, 18'd10, 18'd400, -18'sd100, 18'd380, 18'd4},
    '{18'd360, 18'd10, 18'd360, -18'sd500, -18'sd200, 18'd1},
    '{18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h20000, 18'h1FFFF, 18'h3FFF8},
    '{18'd10, 18'd4, 18'd0, 18'd20, 18'd15, 18'd1},
    '{18'd0, 18'd3, 18'd7, -18'sd3, 18'd9, 18'd0},
    '{18'd50, 18'd0, 18'd0, 18'd0, 18'd50, 18'd3},
    '{18'd100, 18'd8, 18'd64, -18'sd30, 18'd200, 18'd2}
  };

  row_case_t directed_rows [0:NUM_ROWS-1] = '{
    // reset geometry: one empty copy at the row base, or one empty fill
    '{4'd0, 24'd0, 18'sd0, 1'b1, '{1'b0, 48'd0, 22'd0, 1'b1}},
    '{4'd0, 24'hFFFFFF, 18'sd0, 1'b1, '{1'b0, 48'hFFFFFF, 22'd0, 1'b1}},
    '{4'd0, 24'd0, 18'sd1, 1'b1, '{1'b1, 48'd0, 22'd0, 1'b1}},
    '{4'd0, 24'd123, 18'sh20000, 1'b1, '{1'b1, 48'd0, 22'd0, 1'b1}},
    '{4'd0, 24'd7, 18'sd131071, 1'b1, '{1'b1, 48'd0, 22'd0, 1'b1}},
    // padded window without wrap
    '{4'd1, 24'd3, 18'sd50, 1'b1, '{1'b1, 48'd0, 22'd260, 1'b1}},
    '{4'd1, 24'd3, 18'sd49, 1'b0, NO_LITERAL},
    '{4'd1, 24'd0, 18'sd0, 1'b0, NO_LITERAL},
    '{4'd1, 24'd9, -18'sd1, 1'b1, '{1'b1, 48'd0, 22'd260, 1'b1}},
    // all four segments
    '{4'd2, 24'd2, 18'sd5, 1'b0, NO_LITERAL},
    '{4'd2, 24'hFFFFFF, 18'sd9, 1'b0, NO_LITERAL},
    // negative window end, tail from a negative column, reversed main copy
    '{4'd3, 24'd1, 18'sd3, 1'b0, NO_LITERAL},
    '{4'd3, 24'd0, 18'sd10, 1'b1, '{1'b1, 48'd0, 22'd300, 1'b1}},
    // extreme registers
    '{4'd4, 24'hFFFFFF, 18'sd65534, 1'b0, NO_LITERAL},
    '{4'd4, 24'd0, 18'sd65535, 1'b1, '{1'b1, 48'd0, 22'd2097144, 1'b1}},
    '{4'd4, 24'd0, 18'sh20000, 1'b1, '{1'b1, 48'd0, 22'd2097144, 1'b1}},
    // empty request, then a reversed window outside the image
    '{4'd5, 24'd1, 18'sd2, 1'b0, NO_LITERAL},
    '{4'd5, 24'd1, 18'sd4, 1'b1, '{1'b1, 48'd0, 22'd0, 1'b1}},
    // zero row length and zero sample size
    '{4'd6, 24'd5, 18'sd1, 1'b0, NO_LITERAL},
    '{4'd6, 24'd2, 18'sd2, 1'b0, NO_LITERAL},
    // zero row count puts every row outside
    '{4'd7, 24'd0, 18'sd0, 1'b1, '{1'b1, 48'd0, 22'd150, 1'b1}},
    // window wider than the sky circle
    '{4'd8, 24'd4, 18'sd7, 1'b0, NO_LITERAL}
  };

  wrapped_row_segment_generator_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .plane_index_i  (plane_index_i),
    .row_number_i   (row_number_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .fill_zero_o    (fill_zero_o),
    .byte_offset_o  (byte_offset_o),
    .byte_length_o  (byte_length_o),
    .last_segment_o (last_segment_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("wrapped_row_segment_generator_top regression: fail");
    $finish;
  end

  task automatic flag_error(input string msg);
    if (error_count < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) flag_error($sformatf("%s got 0x%0h want 0x%0h", field, got, want));
  endtask

  // one segment; negative pixel counts give length zero, fills carry no offset
  function automatic segment_t segment_of(input logic zero, input logic [63:0] offset,
                                          input longint pixels);
    segment_t    s;
    logic [63:0] bytes;
    bytes            = (pixels < 0) ? 64'd0 : 64'(pixels) * 64'(cur_bpp);
    s.fill_zero      = zero;
    s.byte_offset    = zero ? '0 : offset[wrsg_pkg::OFF_W-1:0];
    s.byte_length    = bytes[wrsg_pkg::LEN_W-1:0];
    s.last_segment   = 1'b0;
    return s;
  endfunction

  // split one row request into its segments and queue them
  function automatic void split_row(input plane_t plane, input row_t row);
    segment_t    row_segs[$];
    longint      y;
    longint      len_px;
    longint      wrap;
    longint      shift;
    longint      x;
    longint      xe;
    longint      n;
    logic [63:0] base;
    y      = longint'(row);
    len_px = longint'(cur_row_length);
    wrap   = longint'(cur_wrap_width);
    if (y < 0 || y >= longint'(cur_row_count)) begin
      row_segs.push_back(segment_of(1'b1, '0, longint'(cur_x_end) - longint'(cur_x_start)));
    end else begin
      base  = ((64'(cur_row_count) * 64'(plane) + 64'(y)) * 64'(cur_row_length))
              * 64'(cur_bpp);
      // division truncates toward zero
      shift = (wrap != 0) ? (longint'(cur_x_end) / wrap) * wrap : 0;
      x     = longint'(cur_x_start) - shift;
      xe    = longint'(cur_x_end) - shift;
      // image tail wrapping in on the left
      if (x < 0 && wrap != 0 && x < len_px - wrap) begin
        n = len_px - wrap - x;
        row_segs.push_back(segment_of(1'b0, base + 64'(len_px - n) * 64'(cur_bpp), n));
        x += n;
      end
      // left pad
      if (x < 0) begin
        n = -x;
        row_segs.push_back(segment_of(1'b1, '0, n));
        x += n;
      end
      // main copy
      if (x < len_px) begin
        n = ((xe < len_px) ? xe : len_px) - x;
        row_segs.push_back(segment_of(1'b0, base + 64'(x) * 64'(cur_bpp), n));
        x += n;
      end
      // right pad
      if (x < xe) row_segs.push_back(segment_of(1'b1, '0, xe - x));
    end
    if (row_segs.size() > 0) row_segs[row_segs.size()-1].last_segment = 1'b1;
    foreach (row_segs[i]) pending_segments.push_back(row_segs[i]);
  endfunction

  // queue predictions on input transactions, check output transactions
  always @(posedge clk_i) begin
    segment_t got;
    segment_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (row_is_literal) pending_segments.push_back(literal_seg);
        else split_row(plane_index_i, row_number_i);
      end
      if (out_valid_o && out_ready_i) begin
        got = '{fill_zero_o, byte_offset_o, byte_length_o, last_segment_o};
        segs_checked++;
        if (pending_segments.size() == 0) begin
          flag_error($sformatf("segment with nothing pending: 0x%0h", got));
        end else begin
          want = pending_segments.pop_front();
          compare_field("fill_zero", 64'(want.fill_zero), 64'(got.fill_zero));
          compare_field("byte_offset", 64'(want.byte_offset), 64'(got.byte_offset));
          compare_field("byte_length", 64'(want.byte_length), 64'(got.byte_length));
          compare_field("last_segment", 64'(want.last_segment), 64'(got.last_segment));
        end
      end
    end
  end

  // output side: random stall before each segment transaction
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // register write, called at a falling edge; caller drops the enable
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      wrsg_pkg::REG_ROW_LENGTH:      cur_row_length = data[15:0];
      wrsg_pkg::REG_ROW_COUNT:       cur_row_count  = data[15:0];
      wrsg_pkg::REG_WRAP_WIDTH:      cur_wrap_width = data[15:0];
      wrsg_pkg::REG_WINDOW_X_START:  cur_x_start    = data;
      wrsg_pkg::REG_WINDOW_X_END:    cur_x_end      = data;
      wrsg_pkg::REG_BYTES_PER_PIXEL: cur_bpp        = data[3:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic load_setting(input setting_t s);
    write_reg(REG_SPARE | cfg_idx_t'($urandom_range(0, 1)), cfg_data_t'($urandom));
    write_reg(wrsg_pkg::REG_ROW_LENGTH, s.row_length);
    write_reg(wrsg_pkg::REG_ROW_COUNT, s.row_count);
    write_reg(wrsg_pkg::REG_WRAP_WIDTH, s.wrap_width);
    write_reg(wrsg_pkg::REG_WINDOW_X_START, s.x_start);
    write_reg(wrsg_pkg::REG_WINDOW_X_END, s.x_end);
    write_reg(wrsg_pkg::REG_BYTES_PER_PIXEL, s.bytes_per_pixel);
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  // one row transaction, entered and left at a falling edge
  task automatic send_row(input plane_t plane, input row_t row,
                          input logic has_literal, input segment_t literal);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    plane_index_i  <= plane;
    row_number_i   <= row;
    row_is_literal <= has_literal;
    literal_seg    <= literal;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    rows_sent++;
  endtask

  // stop requests and let every segment and empty request leave the pipeline
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_segments.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // mostly small well-formed geometry, with full-range and degenerate cases mixed in
  function automatic setting_t random_setting();
    setting_t s;
    int       len;
    int       x1;
    len = $urandom_range(1, 400);
    x1  = int'($urandom_range(0, 1200)) - 600;
    s.row_length = {2'($urandom), 16'(len)};
    s.row_count  = {2'($urandom), 16'($urandom_range(1, 64))};
    case ($urandom_range(0, 3))
      0:       s.wrap_width = {2'($urandom), 16'd0};
      1:       s.wrap_width = {2'($urandom), 16'(len + int'($urandom_range(0, 200)))};
      2:       s.wrap_width = {2'($urandom), 16'($urandom_range(1, len))};
      default: s.wrap_width = {2'($urandom), 16'($urandom_range(1, 1000))};
    endcase
    s.x_start         = 18'(x1);
    s.x_end           = 18'(x1 + int'($urandom_range(0, 900)) - 100);
    s.bytes_per_pixel = {14'($urandom), 4'($urandom_range(1, 8))};
    case ($urandom_range(0, 7))
      0: s = '{18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom),
               18'($urandom), 18'($urandom)};
      1: s.bytes_per_pixel[3:0] = 4'($urandom_range(0, 15));
      2: s.row_length[15:0] = '0;
      default: ;
    endcase
    return s;
  endfunction

  function automatic row_t random_row();
    if (cur_row_count != 0 && $urandom_range(0, 9) < 7)
      return row_t'($urandom_range(0, cur_row_count - 1));
    case ($urandom_range(0, 2))
      0:       return row_t'(-1);
      1:       return row_t'(cur_row_count);
      default: return row_t'($urandom);
    endcase
  endfunction

  // main sequence
  initial begin
    logic [3:0] cur_setting;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    plane_index_i  = '0;
    row_number_i   = '0;
    row_is_literal = 1'b0;
    literal_seg    = '0;
    calm           = 1'b0;
    error_count    = 0;
    rows_sent      = 0;
    segs_checked   = 0;
    settings_loaded = 0;
    cur_setting    = 4'd0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].setting != cur_setting) begin
        drain();
        cur_setting = directed_rows[i].setting;
        load_setting(settings[cur_setting]);
      end
      send_row(directed_rows[i].plane, directed_rows[i].row,
               directed_rows[i].has_literal, directed_rows[i].literal);
    end

    // random rows, a fresh geometry per phase, some stretches without idling
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain();
      load_setting(random_setting());
      for (int j = 0; j < PHASE_ROWS; j++) begin
        if (j % 25 == 0) calm = ($urandom_range(0, 3) == 0);
        send_row($urandom_range(0, 1) ? plane_t'($urandom_range(0, 15)) : plane_t'($urandom),
                 random_row(), 1'b0, NO_LITERAL);
      end
    end
    calm = 1'b0;
    drain();

    $display("covered %0d row transactions and %0d segment transactions",
             rows_sent, segs_checked);
    $display("over %0d register settings, %0d mismatches", settings_loaded, error_count);
    if (error_count == 0) begin
      $display("wrapped_row_segment_generator_top regression: pass");
    end else begin
      $display("wrapped_row_segment_generator_top regression: fail");
    end
    $finish;
  end

endmodule
